@@ hdl/scanline_irq_counter_bank_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Scanline IRQ counter bank mapper: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_IRQ_COUNTER_BANK_MAPPER_DEFINES_SVH
`define SCANLINE_IRQ_COUNTER_BANK_MAPPER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define SCM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge forces the consequent at the next edge
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/scm_pkg.sv @@
// ----------------------------------------------------------------------------
// scm_pkg
// Types and constants shared by the mapper controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  // item kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // register addresses, matched exactly
  localparam logic [15:0] ADDR_NIB0 = 16'h8000;
  localparam logic [15:0] ADDR_NIB1 = 16'h9000;
  localparam logic [15:0] ADDR_NIB2 = 16'hA000;
  localparam logic [15:0] ADDR_NIB3 = 16'hB000;
  localparam logic [15:0] ADDR_CTRL = 16'hC000;
  localparam logic [15:0] ADDR_BANK = 16'hF000;

  localparam logic [6:0] LINE_ADD_ODD  = 7'd113;
  localparam logic [6:0] LINE_ADD_EVEN = 7'd114;

  localparam logic [7:0] ROM_SIZE_RESET = 8'd16;

  // page index is write_data[6:0], reduced by one bit per step
  localparam int          DIV_BITS = 7;
  localparam logic [2:0]  DIV_LAST = 3'(DIV_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } scm_state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
  } scm_ctl_t;

  typedef struct packed {
    logic page_write;
    logic div_last;
  } scm_status_t;

endpackage

`default_nettype wire

@@ hdl/scm_ctrl.sv @@
// ----------------------------------------------------------------------------
// scm_ctrl
// Sequencer for the mapper: accepts an item, runs the page divider when the
// bank register is written, then commits state and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire scm_pkg::scm_status_t status,
  output scm_pkg::scm_ctl_t        ctl
);
  import scm_pkg::*;

  scm_state_t state;
  scm_state_t state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.page_write ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ctl.capture   = 1'b0;
    ctl.div_start = 1'b0;
    ctl.div_step  = 1'b0;
    ctl.commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        ctl.capture   = in_valid;
        ctl.div_start = in_valid && status.page_write;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
      end
      ST_EMIT: begin
        // hold until the result register is empty or draining
        ctl.commit = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scm_datapath.sv @@
// ----------------------------------------------------------------------------
// scm_datapath
// Mapper state (IRQ counter, arm bit, selected page), ROM size register,
// restoring page divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scm_pkg::scm_ctl_t   ctl,
  output scm_pkg::scm_status_t     status,
  input  wire logic                cfg_write,
  input  wire logic [7:0]          cfg_rom_size,
  input  wire logic                cmd,
  input  wire logic [15:0]         address,
  input  wire logic [7:0]          write_data,
  input  wire logic                scanline_odd,
  output logic                     irq_request,
  output logic [7:0]               bank_low_page,
  output logic [7:0]               bank_high_page,
  output logic [15:0]              counter_value,
  output logic                     irq_armed
);
  import scm_pkg::*;

  logic [7:0]  rom_size;
  logic [15:0] irq_count;
  logic        arm_bit;
  logic [7:0]  selected_page;

  logic        item_cmd;
  logic [15:0] item_addr;
  logic [7:0]  item_data;
  logic        item_odd;

  logic [7:0]  rem;
  logic [6:0]  dividend;
  logic [2:0]  div_count;
  logic [8:0]  trial;

  logic [15:0] irq_count_next;
  logic        arm_bit_next;
  logic [7:0]  selected_page_next;
  logic        irq_next;
  logic [16:0] sum;
  logic [15:0] nibble;

  assign status.page_write = (cmd == CMD_WRITE) && (address == ADDR_BANK);
  assign status.div_last   = (div_count == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size      <= ROM_SIZE_RESET;
      irq_count     <= 16'd0;
      arm_bit       <= 1'b0;
      selected_page <= 8'd0;
    end else begin
      if (cfg_write) begin
        rom_size <= cfg_rom_size;
      end
      if (ctl.commit) begin
        irq_count     <= irq_count_next;
        arm_bit       <= arm_bit_next;
        selected_page <= selected_page_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd  <= cmd;
      item_addr <= address;
      item_data <= write_data;
      item_odd  <= scanline_odd;
    end
  end

  // one quotient bit per step; a zero divisor leaves the dividend unreduced
  assign trial = {rem, dividend[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem       <= 8'd0;
      dividend  <= write_data[6:0];
      div_count <= 3'd0;
    end else if (ctl.div_step) begin
      if (trial >= {1'b0, rom_size}) begin
        rem <= 8'(trial - {1'b0, rom_size});
      end else begin
        rem <= trial[7:0];
      end
      dividend  <= {dividend[DIV_BITS-2:0], 1'b0};
      div_count <= div_count + 3'd1;
    end
  end

  // page mod (2*size) equals twice (data[6:0] mod size)
  assign sum    = {1'b0, irq_count} + {10'd0, (item_odd ? LINE_ADD_ODD : LINE_ADD_EVEN)};
  assign nibble = {12'd0, item_data[3:0]};

  always_comb begin
    irq_count_next     = irq_count;
    arm_bit_next       = arm_bit;
    selected_page_next = selected_page;
    irq_next           = 1'b0;
    if (item_cmd == CMD_TICK) begin
      if (arm_bit) begin
        irq_count_next = sum[15:0];
        if (sum[16]) begin
          arm_bit_next = 1'b0;
          irq_next     = 1'b1;
        end
      end
    end else begin
      case (item_addr)
        ADDR_NIB0: irq_count_next = (irq_count & 16'hFFF0) | nibble;
        ADDR_NIB1: irq_count_next = (irq_count & 16'hFF0F) | (nibble << 4);
        ADDR_NIB2: irq_count_next = (irq_count & 16'hF0FF) | (nibble << 8);
        ADDR_NIB3: irq_count_next = (irq_count & 16'h0FFF) | (nibble << 12);
        ADDR_CTRL: arm_bit_next = item_data[1];
        ADDR_BANK: selected_page_next = {rem[6:0], 1'b0};
        default:   irq_count_next = irq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      irq_request    <= irq_next;
      bank_low_page  <= selected_page_next;
      bank_high_page <= selected_page_next + 8'd1;
      counter_value  <= irq_count_next;
      irq_armed      <= arm_bit_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scanline_irq_counter_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// scanline_irq_counter_bank_mapper
// Cartridge mapper with a 16-bit scanline IRQ counter and program bank select.
// ----------------------------------------------------------------------------
// One item at a time. A tick or a register write other than the bank select
// steps through accept and then commit before the next transfer is accepted.
// A bank select write runs the page modulo between accept and commit in a
// restoring divider that resolves one of 7 quotient bits per cycle. Every item
// gives one result, held in an output register so the next item can be taken
// while it waits; a held result delays only the commit of the item after it.
// rom_size_16k may be written at any time the block is idle; cfg_ready is
// always high.
`default_nettype none

`include "scanline_irq_counter_bank_mapper_defines.svh"

module scanline_irq_counter_bank_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic        scanline_odd,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             irq_request,
  output logic [7:0]       bank_low_page,
  output logic [7:0]       bank_high_page,
  output logic [15:0]      counter_value,
  output logic             irq_armed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  rom_size_16k
);
  import scm_pkg::*;

  scm_ctl_t    ctl;
  scm_status_t status;

  assign cfg_ready = 1'b1;

  scm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctl       (ctl)
  );

  scm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_rom_size   (rom_size_16k),
    .cmd            (cmd),
    .address        (address),
    .write_data     (write_data),
    .scanline_odd   (scanline_odd),
    .irq_request    (irq_request),
    .bank_low_page  (bank_low_page),
    .bank_high_page (bank_high_page),
    .counter_value  (counter_value),
    .irq_armed      (irq_armed)
  );

  `SCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not hold off the next one")
  `SCM_ASSERT_ALWAYS(a_irq_disarms, !(out_valid && irq_request && irq_armed), "interrupt result left the counter armed")
  `SCM_ASSERT_ALWAYS(a_page_even, !out_valid || (bank_low_page[0] == 1'b0), "selected page is odd")
  `SCM_ASSERT_ALWAYS(a_page_pair, !out_valid || (bank_high_page == bank_low_page + 8'd1), "bank pair is not adjacent")

endmodule

`default_nettype wire
